// ----- sv/assert_macros.svh -----
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is high.
`define APCP_ASSERT(name, clk, rst, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds across reset.
`define APCP_ASSERT_RST(name, clk, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- sv/apcp_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apcp_pkg
// Shared widths, codes and control types of the APPNP propagation block.
// ----------------------------------------------------------------------------
package apcp_pkg;

  localparam int ChanW   = 6;
  localparam int WeightW = 16;
  localparam int ValueW  = 32;
  localparam int AlphaW  = 16;
  localparam int ResultW = 32;
  localparam int AccW    = 48;
  localparam int OpaW    = 17;
  localparam int ProdW   = 49;
  localparam int CoefW   = 16;
  localparam int TermW   = 35;
  localparam int InitW   = 34;
  localparam int SumW    = 49;

  localparam int SDataW  = 56;   // channel, weight, value -> 54 bits, padded
  localparam int SUserW  = 1;    // func
  localparam int MDataW  = 40;   // result, channel_out -> 38 bits, padded

  localparam int DefMaxChannels = 64;

  localparam logic [AlphaW-1:0] AlphaOne = 16'h8000;   // 1.0 in Q1.15

  typedef enum logic {
    FUNC_ACC = 1'b0,
    FUNC_FIN = 1'b1
  } func_t;

  typedef enum logic [1:0] {
    MUL_COEF = 2'd0,
    MUL_TERM = 2'd1,
    MUL_INIT = 2'd2
  } mul_sel_t;

  typedef struct packed {
    logic     ld_in;
    logic     mul_en;
    mul_sel_t mul_sel;
    logic     acc_ld;
    logic     ram_we;
    logic     wr_zero;
    logic     clr_step;
    logic     out_ld;
  } cmd_t;

  typedef struct packed {
    logic in_range;
    logic clr_last;
    logic out_free;
  } stat_t;

  // saturate a 49-bit sum to the signed 48-bit range
  function automatic logic [AccW-1:0] sat_acc(input logic [SumW-1:0] s);
    logic [AccW-1:0] r;
    if (s[SumW-1] != s[SumW-2]) begin
      r = s[SumW-1] ? {1'b1, {(AccW-1){1'b0}}} : {1'b0, {(AccW-1){1'b1}}};
    end else begin
      r = s[AccW-1:0];
    end
    return r;
  endfunction

  // saturate a 49-bit sum to the signed 32-bit range
  function automatic logic [ResultW-1:0] sat_res(input logic [SumW-1:0] s);
    logic [ResultW-1:0] r;
    if (s[SumW-1:ResultW-1] == '0 || s[SumW-1:ResultW-1] == '1) begin
      r = s[ResultW-1:0];
    end else begin
      r = s[SumW-1] ? {1'b1, {(ResultW-1){1'b0}}} : {1'b0, {(ResultW-1){1'b1}}};
    end
    return r;
  endfunction

endpackage

// ----- sv/appnp_csr_propagate_accumulate.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// appnp_csr_propagate_accumulate
// One APPNP propagation step: per-channel edge accumulation and finish.
// ----------------------------------------------------------------------------
// channel   dir  carries
// s_axis    in   func (tuser), channel / weight / value (tdata)
// m_axis    out  result / channel_out (tdata)
// cfg       in   alpha, Q1.15
//
// Accumulate words pass twice through the shared multiplier (COEF, TERM),
// then the RAM write-back (UPDATE); finish words pass once (INIT), then wait
// in EMIT while an m_tready stall holds the output register. After rst a
// clearing pass zeroes the accumulator RAM; s_tready stays low meanwhile. A
// finished word waits in the output register while the next input word is taken.
// ----------------------------------------------------------------------------
module appnp_csr_propagate_accumulate #(
  parameter int MAX_CHANNELS = apcp_pkg::DefMaxChannels
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [apcp_pkg::AlphaW-1:0]   cfg_data,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [apcp_pkg::SDataW-1:0]   s_tdata,   // channel[5:0], weight[21:6], value[53:22]
  input  logic [apcp_pkg::SUserW-1:0]   s_tuser,   // func[0]
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [apcp_pkg::MDataW-1:0]   m_tdata    // result[31:0], channel_out[37:32]
);
  import apcp_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  apcp_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tuser (s_tuser),
    .stat    (stat),
    .cmd     (cmd)
  );

  apcp_dp #(
    .MAX_CHANNELS(MAX_CHANNELS)
  ) u_dp (
    .clk     (clk),
    .rst     (rst),
    .cfg_we  (cfg_we),
    .cfg_data(cfg_data),
    .s_tdata (s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .cmd     (cmd),
    .stat    (stat)
  );

endmodule

// ----- sv/apcp_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apcp_ram
// Generic simple dual-port RAM, one write port, registered read.
// ----------------------------------------------------------------------------
module apcp_ram #(
  parameter int Width = 48,
  parameter int Depth = 64
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr,
  input  logic [Width-1:0]                           wdata,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr,
  output logic [Width-1:0]                           rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- sv/apcp_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apcp_ctrl
// Sequencer: clearing pass, then one word at a time through the datapath.
// ----------------------------------------------------------------------------
module apcp_ctrl (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [apcp_pkg::SUserW-1:0]        s_tuser,
  input  apcp_pkg::stat_t                    stat,
  output apcp_pkg::cmd_t                     cmd
);
  import apcp_pkg::*;

  typedef enum logic [6:0] {
    ST_CLEAR  = 7'b0000001,
    ST_IDLE   = 7'b0000010,
    ST_COEF   = 7'b0000100,
    ST_TERM   = 7'b0001000,
    ST_UPDATE = 7'b0010000,
    ST_INIT   = 7'b0100000,
    ST_EMIT   = 7'b1000000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    cmd         = '0;
    cmd.mul_sel = MUL_COEF;
    s_tready    = 1'b0;
    unique case (state)
      ST_CLEAR: begin
        cmd.ram_we   = 1'b1;
        cmd.wr_zero  = 1'b1;
        cmd.clr_step = 1'b1;
        if (stat.clr_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.ld_in  = 1'b1;
          state_next = (func_t'(s_tuser[0]) == FUNC_FIN) ? ST_INIT : ST_COEF;
        end
      end
      ST_COEF: begin
        cmd.acc_ld  = 1'b1;
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_COEF;
        state_next  = ST_TERM;
      end
      ST_TERM: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_TERM;
        state_next  = ST_UPDATE;
      end
      ST_UPDATE: begin
        cmd.ram_we = stat.in_range;
        state_next = ST_IDLE;
      end
      ST_INIT: begin
        cmd.acc_ld  = 1'b1;
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_INIT;
        state_next  = ST_EMIT;
      end
      ST_EMIT: begin
        // hold until the output register can take the word
        if (stat.out_free) begin
          cmd.out_ld  = 1'b1;
          cmd.ram_we  = stat.in_range;
          cmd.wr_zero = 1'b1;
          state_next  = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

endmodule

// ----- sv/apcp_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apcp_dp
// Datapath: input latch, shared multiplier, accumulator RAM, output register.
// ----------------------------------------------------------------------------
module apcp_dp #(
  parameter int MAX_CHANNELS = apcp_pkg::DefMaxChannels
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [apcp_pkg::AlphaW-1:0]   cfg_data,
  input  logic [apcp_pkg::SDataW-1:0]   s_tdata,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [apcp_pkg::MDataW-1:0]   m_tdata,
  input  apcp_pkg::cmd_t                cmd,
  output apcp_pkg::stat_t               stat
);
  import apcp_pkg::*;

  localparam int AW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int CW = (AW > ChanW) ? AW : ChanW;

  // input word fields
  logic [ChanW-1:0]   in_ch;
  logic [WeightW-1:0] in_w;
  logic [ValueW-1:0]  in_v;
  assign in_ch = s_tdata[ChanW-1:0];
  assign in_w  = s_tdata[ChanW+WeightW-1:ChanW];
  assign in_v  = s_tdata[ChanW+WeightW+ValueW-1:ChanW+WeightW];

  logic [AlphaW-1:0]  alpha;
  logic [ChanW-1:0]   ch_q;
  logic [WeightW-1:0] w_q;
  logic [ValueW-1:0]  v_q;
  logic               in_range;
  logic [AccW-1:0]    acc_q;
  logic [ProdW-1:0]   prod_q;
  logic [AW-1:0]      clr_cnt;
  logic [ResultW-1:0] res_q;
  logic [ChanW-1:0]   chout_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      alpha <= '0;
    end else if (cfg_we) begin
      alpha <= cfg_data;
    end
  end

  logic [AlphaW-1:0] a_eff;
  logic [AlphaW-1:0] beta;
  assign a_eff = (alpha > AlphaOne) ? AlphaOne : alpha;
  assign beta  = AlphaOne - a_eff;

  // rounded views of the product register
  logic [ProdW-1:0] rnd15;
  logic [ProdW-1:0] rnd14;
  logic [CoefW-1:0] coef;
  logic [TermW-1:0] term;
  logic [InitW-1:0] init;
  assign rnd15 = prod_q + ProdW'(1 << 14);
  assign rnd14 = prod_q + ProdW'(1 << 13);
  assign coef  = rnd15[CoefW+14:15];
  assign term  = rnd14[ProdW-1:14];
  assign init  = rnd15[ProdW-1:15];

  logic signed [OpaW-1:0]   opa;
  logic signed [ValueW-1:0] opb;
  always_comb begin
    unique case (cmd.mul_sel)
      MUL_COEF: begin
        opa = signed'({1'b0, beta});
        opb = signed'({{(ValueW-WeightW){w_q[WeightW-1]}}, w_q});
      end
      MUL_TERM: begin
        opa = signed'({coef[CoefW-1], coef});
        opb = signed'(v_q);
      end
      MUL_INIT: begin
        opa = signed'({1'b0, a_eff});
        opb = signed'(v_q);
      end
      default: begin
        opa = '0;
        opb = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      prod_q <= ProdW'(opa * opb);
    end
  end

  // accumulator RAM
  logic [CW-1:0]    rd_ch_w;
  logic [CW-1:0]    wr_ch_w;
  logic [AW-1:0]    raddr;
  logic [AW-1:0]    waddr;
  logic [AccW-1:0]  wdata;
  logic [AccW-1:0]  rdata;
  logic [SumW-1:0]  acc_sum;
  logic [SumW-1:0]  fin_sum;

  assign rd_ch_w = CW'(cmd.ld_in ? in_ch : ch_q);
  assign wr_ch_w = CW'(ch_q);
  assign raddr   = rd_ch_w[AW-1:0];
  assign waddr   = cmd.clr_step ? clr_cnt : wr_ch_w[AW-1:0];
  assign acc_sum = {acc_q[AccW-1], acc_q} + {{(SumW-TermW){term[TermW-1]}}, term};
  assign fin_sum = {acc_q[AccW-1], acc_q} + {{(SumW-InitW){init[InitW-1]}}, init};
  assign wdata   = cmd.wr_zero ? '0 : sat_acc(acc_sum);

  apcp_ram #(
    .Width(AccW),
    .Depth(MAX_CHANNELS)
  ) u_ram (
    .clk  (clk),
    .we   (cmd.ram_we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (cmd.clr_step) begin
      clr_cnt <= clr_cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ld_in) begin
      ch_q     <= in_ch;
      w_q      <= in_w;
      v_q      <= in_v;
      in_range <= (32'(in_ch) < MAX_CHANNELS);
    end
    if (cmd.acc_ld) begin
      acc_q <= in_range ? rdata : '0;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.out_ld) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_ld) begin
      res_q   <= sat_res(fin_sum);
      chout_q <= ch_q;
    end
  end

  assign m_tdata = {{(MDataW-ResultW-ChanW){1'b0}}, chout_q, res_q};

  assign stat.in_range = in_range;
  assign stat.clr_last = (clr_cnt == AW'(MAX_CHANNELS - 1));
  assign stat.out_free = !m_tvalid || m_tready;

endmodule

// ----- sv/apcp_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apcp_checker
// Port-level checks of the APPNP propagation block, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module apcp_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          s_tvalid,
  input logic                          s_tready,
  input logic                          m_tvalid,
  input logic                          m_tready,
  input logic [apcp_pkg::MDataW-1:0]   m_tdata
);

  // reset starts the clearing pass with nothing to show
  `APCP_ASSERT_RST(a_rst_quiet, clk, rst |=> !s_tready && !m_tvalid, "busy or valid after reset")

  // after a word is taken, s_tready stays low through COEF and TERM, or INIT and EMIT
  `APCP_ASSERT(a_busy_after_accept, clk, rst, s_tvalid && s_tready |=> !s_tready ##1 !s_tready, "word taken too soon after previous")

  // a stalled result holds
  `APCP_ASSERT(a_out_hold, clk, rst, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "result dropped or changed under stall")

  // padding bits of the result word stay zero
  `APCP_ASSERT(a_out_pad, clk, rst, m_tvalid |-> m_tdata[39:38] == 2'b00, "padding bits set in result word")

endmodule

bind appnp_csr_propagate_accumulate apcp_checker u_apcp_checker (.*);

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the APPNP propagation block. Accumulate and finish
// words stream in under random idling on both sides. A fixed-point model of
// the per-channel sums predicts every finished element, and each element on
// m_axis is scoreboarded against it, field by field.
// ----------------------------------------------------------------------------
module tb;
  import apcp_pkg::*;

  localparam longint AccHi = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint AccLo = -AccHi - 1;
  localparam longint ResHi = 64'sh0000_0000_7FFF_FFFF;
  localparam longint ResLo = -ResHi - 1;
  localparam int NumChannels  = DefMaxChannels;
  localparam int SettleCycles = 10;   // lets the last accumulate word retire
  localparam int PhaseWords   = 240;

  typedef struct {
    func_t                     fn;
    logic [ChanW-1:0]          chan;
    logic signed [WeightW-1:0] weight;
    logic signed [ValueW-1:0]  value;
  } prop_word_t;

  typedef struct {
    logic signed [ResultW-1:0] result;
    logic [ChanW-1:0]          chan;
  } node_elem_t;

  logic              clk;
  logic              rst;
  logic              cfg_we;
  logic [AlphaW-1:0] cfg_data;
  logic              s_tvalid;
  logic              s_tready;
  logic [SDataW-1:0] s_tdata;
  logic [SUserW-1:0] s_tuser;
  logic              m_tvalid;
  logic              m_tready;
  logic [MDataW-1:0] m_tdata;

  prop_word_t  word_pending[$];
  node_elem_t  node_expected[$];
  longint      acc_model[NumChannels];
  logic [AlphaW-1:0] alpha_model;
  prop_word_t  next_word;
  node_elem_t  want;
  int          gap_left;
  int          stall_left;
  bit          no_idle;
  int          n_pushed;
  int          n_accepted;
  int          n_results;
  int          n_fail;
  int          n_settings;

  appnp_csr_propagate_accumulate i_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),    // channel[5:0], weight[21:6], value[53:22]
    .s_tuser  (s_tuser),    // func[0]
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)     // result[31:0], channel_out[37:32]
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic longint clip(input longint x, input longint lo, input longint hi);
    if (x < lo) return lo;
    if (x > hi) return hi;
    return x;
  endfunction

  function automatic logic signed [WeightW-1:0] pick_weight();
    logic signed [WeightW-1:0] r;
    r = WeightW'($urandom);
    case ($urandom_range(0, 5))
      0: r = 16'sh7FFF;
      1: r = 16'sh8000;
      2: r = WeightW'($urandom_range(0, 32) - 16);
      default: ;
    endcase
    return r;
  endfunction

  function automatic logic signed [ValueW-1:0] pick_value();
    logic signed [ValueW-1:0] r;
    r = $urandom;
    case ($urandom_range(0, 5))
      0: r = 32'sh7FFF_FFFF;
      1: r = 32'sh8000_0000;
      2: r = $urandom_range(0, 1 << 18) - (1 << 17);
      default: ;
    endcase
    return r;
  endfunction

  // fixed-point propagation step; round half up is add half an LSB, then floor
  function automatic void propagate_word(input func_t fn, input logic [ChanW-1:0] ch,
                                         input logic signed [WeightW-1:0] w,
                                         input logic signed [ValueW-1:0] v);
    longint a;
    longint coef;
    longint term;
    longint init;
    longint acc;
    longint sum;
    node_elem_t e;
    a = (alpha_model > AlphaOne) ? longint'(AlphaOne) : longint'(alpha_model);
    if (fn == FUNC_ACC) begin
      if (ch < NumChannels) begin
        coef = ((32768 - a) * longint'(w) + 16384) >>> 15;
        term = (coef * longint'(v) + 8192) >>> 14;
        acc_model[ch] = clip(acc_model[ch] + term, AccLo, AccHi);
      end
    end else begin
      init = (a * longint'(v) + 16384) >>> 15;
      acc = 0;
      if (ch < NumChannels) begin
        acc = acc_model[ch];
        acc_model[ch] = 0;
      end
      sum = clip(acc + init, ResLo, ResHi);
      e.result = sum[ResultW-1:0];
      e.chan = ch;
      node_expected.push_back(e);
    end
  endfunction

  task automatic note_mismatch(input string what, input longint exp_v, input longint got_v);
    n_fail++;
    if (n_fail <= 10)
      $display("%0t ns %s: expected %0d, got %0d", $time, what, exp_v, got_v);
  endtask

  task automatic queue_word(input func_t fn, input logic [ChanW-1:0] ch,
                            input logic signed [WeightW-1:0] w,
                            input logic signed [ValueW-1:0] v);
    prop_word_t p;
    p.fn = fn;
    p.chan = ch;
    p.weight = w;
    p.value = v;
    word_pending.push_back(p);
    n_pushed++;
  endtask

  task automatic wait_idle();
    do @(negedge clk); while (n_accepted != n_pushed || node_expected.size() != 0);
    repeat (SettleCycles) @(negedge clk);
  endtask

  task automatic write_alpha(input logic [AlphaW-1:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    alpha_model = v;
    n_settings++;
  endtask

  // node rows: a few channels, some edge terms, one finish per channel;
  // one pick in ten is a lone word of either kind
  task automatic random_phase(input int n_words);
    int made;
    int k;
    int n_ch;
    int i;
    logic [ChanW-1:0] chans[4];
    made = 0;
    while (made < n_words) begin
      if ($urandom_range(0, 9) == 0) begin
        queue_word(func_t'($urandom_range(0, 1)), ChanW'($urandom_range(0, 63)),
                   pick_weight(), pick_value());
        made++;
      end else begin
        n_ch = $urandom_range(1, 4);
        for (i = 0; i < n_ch; i++) chans[i] = ChanW'($urandom_range(0, 63));
        k = $urandom_range(0, 10);
        for (i = 0; i < k; i++)
          queue_word(FUNC_ACC, chans[$urandom_range(0, n_ch - 1)], pick_weight(),
                     pick_value());
        for (i = 0; i < n_ch; i++)
          queue_word(FUNC_FIN, chans[i], pick_weight(), pick_value());
        made += k + n_ch;
      end
    end
  endtask

  // sender
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      s_tdata <= '0;
      s_tuser <= '0;
      gap_left <= 0;
    end else if (!s_tvalid || s_tready) begin
      if (gap_left > 0) begin
        s_tvalid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (word_pending.size() > 0) begin
        next_word = word_pending.pop_front();
        s_tvalid <= 1'b1;
        s_tdata <= {2'b00, next_word.value, next_word.weight, next_word.chan};
        s_tuser <= next_word.fn;
        gap_left <= pick_gap();
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // receiver back-pressure
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      m_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      m_tready <= 1'b1;
      stall_left <= ($urandom_range(0, 2) == 0) ? pick_gap() : 0;
    end
  end

  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready) begin
      n_accepted++;
      propagate_word(func_t'(s_tuser[0]), s_tdata[5:0], s_tdata[21:6], s_tdata[53:22]);
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      n_results++;
      if (node_expected.size() == 0) begin
        note_mismatch("result word with nothing outstanding", 0,
                      $signed(m_tdata[ResultW-1:0]));
      end else begin
        want = node_expected.pop_front();
        if (m_tdata[ResultW-1:0] !== want.result)
          note_mismatch("result", want.result, $signed(m_tdata[ResultW-1:0]));
        if (m_tdata[37:32] !== want.chan)
          note_mismatch("channel_out", want.chan, m_tdata[37:32]);
      end
    end
  end

  initial begin
    int i;
    int ph;
    logic [AlphaW-1:0] alpha_set[8];
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_data = '0;
    alpha_model = '0;
    no_idle = 1'b0;
    for (i = 0; i < NumChannels; i++) acc_model[i] = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // alpha at its reset value of zero: full-scale terms, rounding at half an LSB
    queue_word(FUNC_ACC, 6'd0, 16'sh7FFF, 32'sh7FFF_FFFF);
    queue_word(FUNC_ACC, 6'd0, 16'sh8000, 32'sh8000_0000);
    queue_word(FUNC_FIN, 6'd0, 16'sh0000, 32'sh0000_0000);
    queue_word(FUNC_ACC, 6'd63, 16'sh8000, 32'sh7FFF_FFFF);
    queue_word(FUNC_FIN, 6'd63, 16'sh7FFF, 32'sh8000_0000);
    queue_word(FUNC_FIN, 6'd5, 16'sh0000, 32'sd12345);
    queue_word(FUNC_ACC, 6'd1, 16'sd1, 32'sd1);
    queue_word(FUNC_ACC, 6'd1, 16'sd16384, 32'sd1);
    queue_word(FUNC_ACC, 6'd1, 16'sd16384, -32'sd1);
    queue_word(FUNC_ACC, 6'd1, 16'sd0, 32'sh7FFF_FFFF);
    queue_word(FUNC_FIN, 6'd1, 16'sh8000, -32'sd1);
    wait_idle();
    // alpha of one: edge terms vanish
    write_alpha(AlphaOne);
    queue_word(FUNC_ACC, 6'd2, 16'sh7FFF, 32'sh7FFF_FFFF);
    queue_word(FUNC_FIN, 6'd2, 16'sh0000, 32'sh8000_0000);
    queue_word(FUNC_FIN, 6'd2, 16'sh0000, 32'sh7FFF_FFFF);
    queue_word(FUNC_FIN, 6'd3, 16'sh0000, 32'sd1);
    wait_idle();
    // register above one is taken as one
    write_alpha(16'hFFFF);
    queue_word(FUNC_FIN, 6'd4, 16'sh0000, -32'sd1);
    queue_word(FUNC_ACC, 6'd4, 16'sh7FFF, 32'sh7FFF_FFFF);
    queue_word(FUNC_FIN, 6'd4, 16'sh0000, 32'sd3);
    wait_idle();
    write_alpha(16'h4000);
    queue_word(FUNC_ACC, 6'd9, 16'sh7FFF, 32'sh7FFF_FFFF);
    queue_word(FUNC_ACC, 6'd9, 16'sh8000, 32'sd1);
    queue_word(FUNC_FIN, 6'd9, 16'sh0000, 32'sd1);
    queue_word(FUNC_FIN, 6'd9, 16'sh0000, -32'sd1);
    wait_idle();

    alpha_set[0] = 16'h0000;
    alpha_set[1] = 16'h0001;
    alpha_set[2] = 16'h7FFF;
    alpha_set[3] = AlphaOne;
    alpha_set[4] = 16'h8001;
    alpha_set[5] = 16'hFFFF;
    alpha_set[6] = AlphaW'($urandom_range(0, 32768));
    alpha_set[7] = AlphaW'($urandom);
    for (ph = 0; ph < 8; ph++) begin
      no_idle = (ph == 2 || ph == 5);
      write_alpha(alpha_set[ph]);
      random_phase(PhaseWords);
      wait_idle();
    end
    repeat (20) @(posedge clk);

    $display("%0d words in, %0d finished elements checked, %0d alpha settings",
             n_accepted, n_results, n_settings);
    $display("edge and finish words over all channels, alpha from zero to past one");
    if (n_fail == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("%0d mismatches", n_fail);
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("timed out with %0d words queued, %0d elements outstanding",
             word_pending.size(), node_expected.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+sv
sv/apcp_pkg.sv
sv/apcp_ram.sv
sv/apcp_ctrl.sv
sv/apcp_dp.sv
sv/appnp_csr_propagate_accumulate.sv
sv/apcp_checker.sv
tb/tb.sv
